>>> rtl/fra_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the frame ring allocator.
package fra_pkg;

  // Item modes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FINISH  = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_Q_FULL   = 2'd2;

  // Ring size register after reset
  localparam logic [16:0] RING_SIZE_RESET = 17'h10000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] request_bytes;
    logic [63:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [16:0] used_bytes;
    logic [4:0]  released_frames;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec_simple;
    logic pop;
    logic emit_release;
  } fra_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_release;
    logic out_free;
    logic queue_empty;
    logic pop_ok;
  } fra_stat_t;

endpackage

>>> rtl/fra_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the frame ring allocator.
module fra_ctrl import fra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  fra_stat_t stat,
  output fra_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_release) begin
          state_next = ST_READ;
        end else if (stat.out_free) begin
          cmd.exec_simple = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_READ: begin
        // marker head is fetched this cycle
        state_next = stat.queue_empty ? ST_FINAL : ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.pop_ok) begin
          cmd.pop    = 1'b1;
          state_next = ST_READ;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_release = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/fra_datapath.sv
`timescale 1ns / 1ps
// Ring pointers, marker queue memory and result register of the allocator.
module fra_datapath import fra_pkg::*; #(
  parameter int MAX_RING_BYTES = 65536,
  parameter int MIN_RING_BYTES = 256,
  parameter int MARKER_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  in_item_t    in_item,
  input  fra_cmd_t    cmd,
  output fra_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  localparam int OFS_W = $clog2(MAX_RING_BYTES + 1);
  localparam int CW    = ((OFS_W > 17) ? OFS_W : 17) + 1;
  localparam int PTR_W = $clog2(MARKER_DEPTH);
  localparam int CNT_W = $clog2(MARKER_DEPTH + 1);
  localparam int MEM_W = 2 * OFS_W + 64;

  logic [16:0]      ring_size;
  logic [OFS_W-1:0] head_offset;
  logic [OFS_W-1:0] tail_offset;
  logic [OFS_W-1:0] used_count;
  logic [OFS_W-1:0] frame_bytes;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] marker_count;
  logic [CNT_W-1:0] released;
  in_item_t         item;
  out_item_t        result;

  logic [MEM_W-1:0] marker_mem [MARKER_DEPTH];
  logic [MEM_W-1:0] rd_data;

  logic [OFS_W-1:0] m_tail;
  logic [OFS_W-1:0] m_bytes;
  logic [63:0]      m_frame;

  logic [CW-1:0]    size_a;
  logic [CW-1:0]    size_e;
  logic [CW-1:0]    head_w;
  logic [CW-1:0]    tail_w;
  logic [CW-1:0]    used_w;
  logic [CW-1:0]    fb_w;
  logic [CW-1:0]    req_w;
  logic [CW-1:0]    tail_plus;
  logic [CW-1:0]    skip;
  logic [CW:0]      used_wrap;
  logic [CW:0]      fb_wrap;

  logic             grant;
  logic [OFS_W-1:0] tail_new;
  logic [OFS_W-1:0] used_new;
  logic [OFS_W-1:0] fb_new;
  logic [OFS_W-1:0] grant_offset;
  logic [OFS_W-1:0] used_pop;
  logic             q_full;
  logic             push;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic [PTR_W-1:0] wr_ptr_inc;
  logic [1:0]       simple_status;

  assign {m_tail, m_bytes, m_frame} = rd_data;

  // Clamp the ring size into the legal range
  assign size_a = (CW'(ring_size) < CW'(MIN_RING_BYTES)) ? CW'(MIN_RING_BYTES)
                                                          : CW'(ring_size);
  assign size_e = (size_a > CW'(MAX_RING_BYTES)) ? CW'(MAX_RING_BYTES) : size_a;

  assign head_w    = CW'(head_offset);
  assign tail_w    = CW'(tail_offset);
  assign used_w    = CW'(used_count);
  assign fb_w      = CW'(frame_bytes);
  assign req_w     = CW'(item.request_bytes);
  assign tail_plus = tail_w + req_w;
  assign skip      = (size_e > tail_w) ? (size_e - tail_w) : '0;
  assign used_wrap = (CW + 1)'(used_w) + (CW + 1)'(skip) + (CW + 1)'(req_w);
  assign fb_wrap   = (CW + 1)'(fb_w) + (CW + 1)'(skip) + (CW + 1)'(req_w);

  // Place an allocation at the tail, or wrap it to offset zero
  always_comb begin
    grant        = 1'b0;
    tail_new     = tail_offset;
    used_new     = used_count;
    fb_new       = frame_bytes;
    grant_offset = '0;
    if (used_w >= size_e) begin
      grant = 1'b0;
    end else if (tail_w >= head_w) begin
      if (tail_plus <= size_e) begin
        grant        = 1'b1;
        grant_offset = tail_offset;
        tail_new     = OFS_W'(tail_plus);
        used_new     = OFS_W'(used_w + req_w);
        fb_new       = OFS_W'(fb_w + req_w);
      end else if (req_w <= head_w) begin
        grant    = 1'b1;
        tail_new = OFS_W'(req_w);
        used_new = OFS_W'(used_wrap);
        fb_new   = OFS_W'(fb_wrap);
      end
    end else if (tail_plus <= head_w) begin
      grant        = 1'b1;
      grant_offset = tail_offset;
      tail_new     = OFS_W'(tail_plus);
      used_new     = OFS_W'(used_w + req_w);
      fb_new       = OFS_W'(fb_w + req_w);
    end
  end

  assign q_full     = (marker_count == CNT_W'(MARKER_DEPTH));
  assign push       = cmd.exec_simple && (item.mode == MODE_FINISH) && !q_full;
  assign used_pop   = (used_count >= m_bytes) ? (used_count - m_bytes) : '0;
  assign rd_ptr_inc = (rd_ptr == PTR_W'(MARKER_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc = (wr_ptr == PTR_W'(MARKER_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;

  always_comb begin
    simple_status = STATUS_OK;
    if (item.mode == MODE_ALLOC && !grant) begin
      simple_status = STATUS_NO_SPACE;
    end else if (item.mode == MODE_FINISH && q_full) begin
      simple_status = STATUS_Q_FULL;
    end
  end

  // Status toward the controller
  assign stat.is_release  = (item.mode == MODE_RELEASE);
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.queue_empty = (marker_count == '0);
  assign stat.pop_ok      = (m_frame <= item.frame_number);

  assign out_item = result;

  // Ring state and marker queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size    <= RING_SIZE_RESET;
      head_offset  <= '0;
      tail_offset  <= '0;
      used_count   <= '0;
      frame_bytes  <= '0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      marker_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Raise the result when an item finishes, drop it once taken
      if (!cfg_we && (cmd.exec_simple || cmd.emit_release)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        ring_size    <= cfg_data;
        head_offset  <= '0;
        tail_offset  <= '0;
        used_count   <= '0;
        frame_bytes  <= '0;
        rd_ptr       <= '0;
        wr_ptr       <= '0;
        marker_count <= '0;
      end else begin
        if (cmd.exec_simple) begin
          if (item.mode == MODE_ALLOC && grant) begin
            tail_offset <= tail_new;
            used_count  <= used_new;
            frame_bytes <= fb_new;
          end
          if (push) begin
            wr_ptr       <= wr_ptr_inc;
            marker_count <= marker_count + 1'b1;
            frame_bytes  <= '0;
          end
        end
        if (cmd.pop) begin
          used_count   <= used_pop;
          head_offset  <= m_tail;
          rd_ptr       <= rd_ptr_inc;
          marker_count <= marker_count - 1'b1;
        end
      end
    end
  end

  // Hold the item, count pops and build the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item     <= in_item;
      released <= '0;
    end else if (cmd.pop) begin
      released <= released + 1'b1;
    end
    if (cmd.exec_simple) begin
      result.status          <= simple_status;
      result.offset          <= (item.mode == MODE_ALLOC && grant) ? 16'(grant_offset) : '0;
      result.used_bytes      <= (item.mode == MODE_ALLOC && grant) ? 17'(used_new)
                                                                  : 17'(used_count);
      result.released_frames <= '0;
    end else if (cmd.emit_release) begin
      result.status          <= STATUS_OK;
      result.offset          <= '0;
      result.used_bytes      <= 17'(used_count);
      result.released_frames <= 5'(released);
    end
  end

  // Marker queue memory
  always_ff @(posedge clk) begin
    if (push && !cfg_we) begin
      marker_mem[wr_ptr] <= {tail_offset, frame_bytes, item.frame_number};
    end
    rd_data <= marker_mem[rd_ptr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    marker_count <= CNT_W'(MARKER_DEPTH))
    else $error("marker count above queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    marker_count == '0 |-> rd_ptr == wr_ptr)
    else $error("empty marker queue with unequal pointers");

  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (marker_count != '0) && (m_frame <= item.frame_number))
    else $error("marker popped from empty queue or above bound");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec_simple || cmd.emit_release) |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

>>> rtl/frame_ring_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the frame ring allocator: controller plus datapath.
//
//  channel  | signals                      | transfer
//  ---------+------------------------------+------------------------------
//  input    | in_valid, in_ready, in_item  | valid and ready high at edge
//  output   | out_valid, out_ready, out_item | valid and ready high at edge
//  config   | cfg_we, cfg_data             | cfg_we high at edge
//
// Allocate, finish and unused-mode items: the item is registered on accept,
// then the execute state registers the result and returns to idle.
// Release: execute, then read and check once per marker popped, then final;
// each pop costs a registered read of the marker memory and a compare.
// One item is worked at a time; in_ready is high whenever the controller is
// idle, even while the previous result waits on out_ready.
// A waiting result stalls only the finishing step of the next item.
// Reset and a ring_size write both empty the ring and the marker queue.
module frame_ring_allocator_top import fra_pkg::*; #(
  parameter int MAX_RING_BYTES = 65536,
  parameter int MIN_RING_BYTES = 256,
  parameter int MARKER_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  fra_cmd_t  cmd;
  fra_stat_t stat;

  // Sequence each item
  fra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold ring state and marker queue
  fra_datapath #(
    .MAX_RING_BYTES (MAX_RING_BYTES),
    .MIN_RING_BYTES (MIN_RING_BYTES),
    .MARKER_DEPTH   (MARKER_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> tb/tb_frame_ring_allocator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_ring_allocator_top: directed and random traffic.
module tb_frame_ring_allocator_top;
  import fra_pkg::*;

  localparam int          RING_MAX      = 65536;
  localparam int          RING_MIN      = 256;
  localparam int          MARKER_SLOTS  = 16;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_AT       = 350;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam logic [63:0] FRAME_ALL     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] tail;
    logic [31:0] bytes;
    logic [63:0] frame;
  } frame_marker_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  // Ring state as the block should hold it
  logic [16:0]   ring_cfg;
  logic [31:0]   head_q;
  logic [31:0]   tail_q;
  logic [31:0]   used_q;
  logic [31:0]   frame_bytes_q;
  frame_marker_t marker_q[$];

  in_item_t  item_backlog[$];
  out_item_t predicted_results[$];

  int send_gap_pct = 27;
  int recv_gap_pct = 27;
  int fail_count = 0;
  int results_checked = 0;
  int stall_cycles = 0;
  int n_granted = 0;
  int n_no_space = 0;
  int n_queue_full = 0;
  int n_release_pops = 0;
  int max_popped = 0;
  int settings_used = 0;
  logic [63:0] next_frame;

  frame_ring_allocator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Empty the ring and the marker queue
  task automatic ring_clear();
    head_q = '0;
    tail_q = '0;
    used_q = '0;
    frame_bytes_q = '0;
    marker_q.delete();
  endtask

  function automatic logic [31:0] ring_capacity();
    if (ring_cfg < RING_MIN) return RING_MIN;
    if (ring_cfg > RING_MAX) return RING_MAX;
    return 32'(ring_cfg);
  endfunction

  // Advance the ring state by one item and return the result it should give
  function automatic out_item_t ring_step(in_item_t it);
    logic [31:0]   cap;
    logic [31:0]   req;
    logic [31:0]   skip;
    logic [31:0]   grant_at;
    logic [31:0]   popped;
    logic          granted;
    frame_marker_t m;
    out_item_t     r;
    cap = ring_capacity();
    req = 32'(it.request_bytes);
    grant_at = '0;
    popped = '0;
    granted = 1'b0;
    r = '0;
    r.status = STATUS_OK;
    case (it.mode)
      MODE_ALLOC: begin
        if (used_q >= cap) begin
          granted = 1'b0;
        end else if (tail_q >= head_q) begin
          if (tail_q + req <= cap) begin
            grant_at = tail_q;
            tail_q += req;
            used_q += req;
            frame_bytes_q += req;
            granted = 1'b1;
          end else if (req <= head_q) begin
            // wrap to the start, charge the skipped end bytes to the frame
            skip = (cap > tail_q) ? cap - tail_q : 32'd0;
            used_q += skip + req;
            frame_bytes_q += skip + req;
            tail_q = req;
            grant_at = '0;
            granted = 1'b1;
          end
        end else if (tail_q + req <= head_q) begin
          grant_at = tail_q;
          tail_q += req;
          used_q += req;
          frame_bytes_q += req;
          granted = 1'b1;
        end
        if (granted) begin
          r.offset = grant_at[15:0];
          n_granted++;
        end else begin
          r.status = STATUS_NO_SPACE;
          n_no_space++;
        end
      end
      MODE_FINISH: begin
        if (marker_q.size() >= MARKER_SLOTS) begin
          r.status = STATUS_Q_FULL;
          n_queue_full++;
        end else begin
          m.tail = tail_q;
          m.bytes = frame_bytes_q;
          m.frame = it.frame_number;
          marker_q.push_back(m);
          frame_bytes_q = '0;
        end
      end
      MODE_RELEASE: begin
        while (marker_q.size() > 0 && marker_q[0].frame <= it.frame_number) begin
          m = marker_q[0];
          marker_q.delete(0);
          used_q = (used_q >= m.bytes) ? used_q - m.bytes : 32'd0;
          head_q = m.tail;
          popped++;
        end
        if (popped > 0) n_release_pops++;
        if (int'(popped) > max_popped) max_popped = int'(popped);
      end
      default: ;
    endcase
    r.used_bytes = used_q[16:0];
    r.released_frames = popped[4:0];
    return r;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Feed items from the backlog, predict each accepted one
  always @(posedge clk) begin : item_driver
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) predicted_results.push_back(ring_step(in_item));
      if (!in_valid || take) begin
        if (item_backlog.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_item <= item_backlog[0];
          item_backlog.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check results against predictions, hold off once for a long stretch
  always @(posedge clk) begin : result_monitor
    int        hold_left;
    logic      next_ready;
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d offset %0d used %0d released %0d",
                                 out_item.status, out_item.offset, out_item.used_bytes,
                                 out_item.released_frames));
        end else begin
          want = predicted_results[0];
          predicted_results.delete(0);
          if (out_item.status !== want.status || out_item.offset !== want.offset ||
              out_item.used_bytes !== want.used_bytes ||
              out_item.released_frames !== want.released_frames) begin
            note_failure($sformatf(
              "result %0d: expected status %0d offset %0d used %0d released %0d, got %0d %0d %0d %0d",
              results_checked, want.status, want.offset, want.used_bytes, want.released_frames,
              out_item.status, out_item.offset, out_item.used_bytes, out_item.released_frames));
          end
        end
        results_checked++;
        if (results_checked == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = ($urandom_range(0, 99) >= recv_gap_pct);
      end
      out_ready <= next_ready;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("frame_ring_allocator_top regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic offer(logic [1:0] mode, logic [16:0] req, logic [63:0] frame);
    in_item_t it;
    it.mode = mode;
    it.request_bytes = req;
    it.frame_number = frame;
    item_backlog.push_back(it);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // Write the ring size while the block is idle
  task automatic set_ring(logic [16:0] value);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_cfg = value;
    ring_clear();
    settings_used++;
  endtask

  // Mostly frames of allocations closed and released with some lag, plus noise
  task automatic random_traffic(int count, int release_pct);
    int          pick;
    int          sel;
    logic [31:0] cap;
    logic [16:0] req;
    cap = ring_capacity();
    next_frame = {$urandom, $urandom};
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        sel = $urandom_range(0, 2);
        if (sel == 0)
          offer(MODE_UNUSED, 17'($urandom_range(0, 131071)), {$urandom, $urandom});
        else if (sel == 1)
          offer(MODE_RELEASE, 17'($urandom_range(0, 131071)), {$urandom, $urandom});
        else
          offer(MODE_FINISH, 17'($urandom_range(0, 131071)), {$urandom, $urandom});
      end else if (pick < 5 + release_pct) begin
        if ($urandom_range(0, 9) == 0)
          offer(MODE_RELEASE, '0, FRAME_ALL);
        else
          offer(MODE_RELEASE, '0, next_frame - 64'($urandom_range(1, 5)));
      end else if (pick < 23 + release_pct) begin
        offer(MODE_FINISH, '0, next_frame);
        next_frame++;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0) req = '0;
        else if (sel == 1) req = 17'($urandom_range(0, 131071));
        else if (sel == 2) req = 17'($urandom_range(cap / 2, cap));
        else req = 17'($urandom_range(1, cap / 6));
        offer(MODE_ALLOC, req, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    ring_cfg = RING_SIZE_RESET;
    ring_clear();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset size: exact fill, full ring, offset at ring end, wrap, all-ones bounds
    offer(MODE_ALLOC,   17'd0,      64'd0);
    offer(MODE_ALLOC,   17'd65536,  64'd0);
    offer(MODE_ALLOC,   17'd1,      64'd0);
    offer(MODE_UNUSED,  17'h1FFFF,  FRAME_ALL);
    offer(MODE_FINISH,  17'd0,      64'd0);
    offer(MODE_RELEASE, 17'd0,      64'd0);
    offer(MODE_ALLOC,   17'd0,      64'd0);
    offer(MODE_ALLOC,   17'h1FFFF,  64'd0);
    offer(MODE_ALLOC,   17'd100,    64'd0);
    offer(MODE_FINISH,  17'd0,      FRAME_ALL);
    offer(MODE_RELEASE, 17'd0,      FRAME_ALL - 64'd1);
    offer(MODE_RELEASE, 17'd0,      FRAME_ALL);
    offer(MODE_ALLOC,   17'd50,     64'd0);
    random_traffic(120, 20);

    // Smallest ring: no fit without room below head, wrap with skipped bytes
    set_ring(17'd0);
    offer(MODE_ALLOC,   17'd200, 64'd0);
    offer(MODE_ALLOC,   17'd100, 64'd0);
    offer(MODE_FINISH,  17'd0,   64'd5);
    offer(MODE_RELEASE, 17'd0,   64'd4);
    offer(MODE_RELEASE, 17'd0,   64'd5);
    offer(MODE_ALLOC,   17'd100, 64'd0);
    offer(MODE_ALLOC,   17'd100, 64'd0);
    offer(MODE_ALLOC,   17'd0,   64'd0);
    offer(MODE_FINISH,  17'd0,   64'd6);
    offer(MODE_RELEASE, 17'd0,   64'd6);
    random_traffic(150, 20);

    // Oversized register value, rare releases to fill the marker queue
    set_ring(17'h1FFFF);
    random_traffic(120, 3);

    // Run with no idling on either side
    set_ring(17'd1);
    drain();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_traffic(120, 20);
    drain();
    send_gap_pct = 27;
    recv_gap_pct = 27;

    set_ring(17'd255);
    random_traffic(100, 20);
    set_ring(17'd257);
    random_traffic(100, 15);
    set_ring(17'd1000);
    random_traffic(100, 20);
    set_ring(17'd65535);
    random_traffic(100, 10);
    set_ring(17'd65536);
    random_traffic(100, 20);
    set_ring(17'($urandom_range(256, 4096)));
    random_traffic(100, 20);

    drain();
    repeat (50) @(posedge clk);
    if (predicted_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_results.size()));

    $display("covered %0d results over %0d ring sizes: %0d grants, %0d refused for space,",
             results_checked, settings_used + 1, n_granted, n_no_space);
    $display("%0d finishes on a full marker queue, %0d releases that popped (most %0d at once)",
             n_queue_full, n_release_pops, max_popped);
    if (fail_count == 0) begin
      $display("frame_ring_allocator_top regression: pass");
    end else begin
      $display("frame_ring_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
